[hdl/via_pkg.sv]
// Shared types and constants for the versatile interface adapter.
// No dependencies; imported by every module of the block.
package via_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // register map, index = bus_address[12:9]
  localparam logic [3:0] REG_ORB    = 4'd0;
  localparam logic [3:0] REG_ORA    = 4'd1;
  localparam logic [3:0] REG_DDRB   = 4'd2;
  localparam logic [3:0] REG_DDRA   = 4'd3;
  localparam logic [3:0] REG_T1CL   = 4'd4;
  localparam logic [3:0] REG_T1CH   = 4'd5;
  localparam logic [3:0] REG_T1LL   = 4'd6;
  localparam logic [3:0] REG_T1LH   = 4'd7;
  localparam logic [3:0] REG_T2CL   = 4'd8;
  localparam logic [3:0] REG_T2CH   = 4'd9;
  localparam logic [3:0] REG_SR     = 4'd10;
  localparam logic [3:0] REG_ACR    = 4'd11;
  localparam logic [3:0] REG_PCR    = 4'd12;
  localparam logic [3:0] REG_IFR    = 4'd13;
  localparam logic [3:0] REG_IER    = 4'd14;
  localparam logic [3:0] REG_ORA_NH = 4'd15;

  localparam int FLAG_T1     = 6;
  localparam int FLAG_T2     = 5;
  localparam int ACR_T1_FREE = 6;
  localparam int ACR_T2_HOLD = 5;
  localparam int IER_SET     = 7;

  localparam int CNT_W   = 32;
  localparam int LATCH_W = 16;
  localparam int FLAG_W  = 7;

  typedef struct packed {
    cmd_t       cmd;
    logic [3:0] idx;
    logic [7:0] wdata;
    logic [7:0] cycles;
    logic [7:0] pa_pins;
    logic [7:0] pb_pins;
  } item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
    logic [7:0] pa_drive;
    logic [7:0] pa_dir;
    logic [7:0] pb_drive;
    logic [7:0] pb_dir;
  } result_t;

endpackage

[hdl/via_timer.sv]
// One timer's count-down for a tick item: subtract, expiry test, reload.
// Depends on via_pkg.
module via_timer
  import via_pkg::*;
(
  input  logic [CNT_W-1:0]   count,
  input  logic [7:0]         cycles,
  input  logic               reload_en,
  input  logic [LATCH_W-1:0] latch,
  output logic [CNT_W-1:0]   count_next,
  output logic               expired
);

  logic [CNT_W-1:0] diff;
  logic             was_pos;
  logic             now_nonpos;

  always_comb begin
    diff       = count - {{(CNT_W-8){1'b0}}, cycles};
    was_pos    = (count != '0) && !count[CNT_W-1];
    now_nonpos = (diff == '0) || diff[CNT_W-1];
    expired    = was_pos && now_nonpos;
    // free-run mode adds the latch back once on expiry
    if (expired && reload_en) begin
      count_next = diff + {{(CNT_W-LATCH_W){1'b0}}, latch};
    end else begin
      count_next = diff;
    end
  end

endmodule

[hdl/via_core.sv]
// Register file and per-item update of the adapter: bus decode, timers, flags.
// Depends on via_pkg and via_timer.
module via_core
  import via_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  output result_t result
);

  logic [7:0]         out_a, out_b, dir_a, dir_b;
  logic [CNT_W-1:0]   t1_count, t2_count;
  logic [LATCH_W-1:0] t1_latch, t2_latch;
  logic [7:0]         shift_byte, aux_control, periph_control;
  logic [FLAG_W-1:0]  irq_flags, irq_enables;

  logic [7:0]         out_a_next, out_b_next, dir_a_next, dir_b_next;
  logic [CNT_W-1:0]   t1_count_next, t2_count_next;
  logic [LATCH_W-1:0] t1_latch_next, t2_latch_next;
  logic [7:0]         shift_byte_next, aux_control_next, periph_control_next;
  logic [FLAG_W-1:0]  irq_flags_next, irq_enables_next;
  logic [7:0]         rdata;

  logic [CNT_W-1:0]   t1_tick, t2_tick;
  logic               t1_exp, t2_exp;

  via_timer u_t1 (
    .count      (t1_count),
    .cycles     (item.cycles),
    .reload_en  (aux_control[ACR_T1_FREE]),
    .latch      (t1_latch),
    .count_next (t1_tick),
    .expired    (t1_exp)
  );

  via_timer u_t2 (
    .count      (t2_count),
    .cycles     (item.cycles),
    .reload_en  (1'b0),
    .latch      (t2_latch),
    .count_next (t2_tick),
    .expired    (t2_exp)
  );

  always_comb begin
    out_a_next          = out_a;
    out_b_next          = out_b;
    dir_a_next          = dir_a;
    dir_b_next          = dir_b;
    t1_count_next       = t1_count;
    t2_count_next       = t2_count;
    t1_latch_next       = t1_latch;
    t2_latch_next       = t2_latch;
    shift_byte_next     = shift_byte;
    aux_control_next    = aux_control;
    periph_control_next = periph_control;
    irq_flags_next      = irq_flags;
    irq_enables_next    = irq_enables;
    rdata               = '0;

    case (item.cmd)
      CMD_READ: begin
        case (item.idx)
          REG_ORB:             rdata = (out_b & dir_b) | (item.pb_pins & ~dir_b);
          REG_ORA, REG_ORA_NH: rdata = (out_a & dir_a) | (item.pa_pins & ~dir_a);
          REG_DDRB:            rdata = dir_b;
          REG_DDRA:            rdata = dir_a;
          REG_T1CL: begin
            rdata                   = t1_count[7:0];
            irq_flags_next[FLAG_T1] = 1'b0;
          end
          REG_T1CH:            rdata = t1_count[15:8];
          REG_T1LL:            rdata = t1_latch[7:0];
          REG_T1LH:            rdata = t1_latch[15:8];
          REG_T2CL: begin
            rdata                   = t2_count[7:0];
            irq_flags_next[FLAG_T2] = 1'b0;
          end
          REG_T2CH:            rdata = t2_count[15:8];
          REG_SR:              rdata = shift_byte;
          REG_ACR:             rdata = aux_control;
          REG_PCR:             rdata = periph_control;
          REG_IFR:             rdata = {|(irq_flags & irq_enables), irq_flags};
          default:             rdata = {1'b1, irq_enables};
        endcase
      end
      CMD_WRITE: begin
        case (item.idx)
          REG_ORB:             out_b_next = item.wdata;
          REG_ORA, REG_ORA_NH: out_a_next = item.wdata;
          REG_DDRB:            dir_b_next = item.wdata;
          REG_DDRA:            dir_a_next = item.wdata;
          REG_T1CL, REG_T1LL:  t1_latch_next = {t1_latch[15:8], item.wdata};
          REG_T1CH: begin
            t1_latch_next           = {item.wdata, t1_latch[7:0]};
            t1_count_next           = {{(CNT_W-LATCH_W){1'b0}}, item.wdata,
                                       t1_latch[7:0]};
            irq_flags_next[FLAG_T1] = 1'b0;
          end
          REG_T1LH:            t1_latch_next = {item.wdata, t1_latch[7:0]};
          REG_T2CL:            t2_latch_next = {t2_latch[15:8], item.wdata};
          REG_T2CH: begin
            t2_count_next           = {{(CNT_W-LATCH_W){1'b0}}, item.wdata,
                                       t2_latch[7:0]};
            irq_flags_next[FLAG_T2] = 1'b0;
          end
          REG_SR:              shift_byte_next = item.wdata;
          REG_ACR:             aux_control_next = item.wdata;
          REG_PCR:             periph_control_next = item.wdata;
          REG_IFR:             irq_flags_next = irq_flags & ~item.wdata[FLAG_W-1:0];
          default: begin
            if (item.wdata[IER_SET]) begin
              irq_enables_next = irq_enables | item.wdata[FLAG_W-1:0];
            end else begin
              irq_enables_next = irq_enables & ~item.wdata[FLAG_W-1:0];
            end
          end
        endcase
      end
      CMD_TICK: begin
        t1_count_next = t1_tick;
        if (t1_exp) begin
          irq_flags_next[FLAG_T1] = 1'b1;
        end
        // timer 2 holds while ACR bit 5 is set
        if (!aux_control[ACR_T2_HOLD]) begin
          t2_count_next = t2_tick;
          if (t2_exp) begin
            irq_flags_next[FLAG_T2] = 1'b1;
          end
        end
      end
      default: ;
    endcase

    result.rdata    = rdata;
    result.irq      = |(irq_flags_next & irq_enables_next);
    result.pa_drive = out_a_next;
    result.pa_dir   = dir_a_next;
    result.pb_drive = out_b_next;
    result.pb_dir   = dir_b_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_a          <= '0;
      out_b          <= '0;
      dir_a          <= '0;
      dir_b          <= '0;
      t1_count       <= '0;
      t2_count       <= '0;
      t1_latch       <= '0;
      t2_latch       <= '0;
      shift_byte     <= '0;
      aux_control    <= '0;
      periph_control <= '0;
      irq_flags      <= '0;
      irq_enables    <= '0;
    end else if (step) begin
      out_a          <= out_a_next;
      out_b          <= out_b_next;
      dir_a          <= dir_a_next;
      dir_b          <= dir_b_next;
      t1_count       <= t1_count_next;
      t2_count       <= t2_count_next;
      t1_latch       <= t1_latch_next;
      t2_latch       <= t2_latch_next;
      shift_byte     <= shift_byte_next;
      aux_control    <= aux_control_next;
      periph_control <= periph_control_next;
      irq_flags      <= irq_flags_next;
      irq_enables    <= irq_enables_next;
    end
  end

endmodule

[hdl/versatile_interface_adapter_unit.sv]
// Versatile interface adapter, top level: input register, core, result register.
// Depends on via_pkg and via_core.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: a bus read, a bus write
//   or a timer tick (cmd), with address, write byte, tick length and the pin
//   levels of both ports. Output channel (out_valid/out_ready) returns one
//   result per item: read byte (zero unless a read), interrupt line and the
//   port output and direction registers as they stand after the item.
//   Throughput: one item per clock while the receiver does not stall; the whole
//   register update is one pass through the core between the input register
//   and the result register, and out_valid rises once the result is registered.
//   Reset (rst, synchronous) clears all adapter registers, timers and flags
//   and empties both pipeline registers.
//   When the receiver stalls, the result register holds, the item in the input
//   register waits, and in_ready falls once both are full; no item is lost.
module versatile_interface_adapter_unit
  import via_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [12:0] bus_address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  tick_cycles,
  input  logic [7:0]  port_a_pins,
  input  logic [7:0]  port_b_pins,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        irq_line,
  output logic [7:0]  port_a_drive,
  output logic [7:0]  port_a_dir,
  output logic [7:0]  port_b_drive,
  output logic [7:0]  port_b_dir
);

  logic    s1_valid;
  item_t   s1_item;
  logic    s1_adv;
  logic    step;
  result_t core_res;
  result_t res;

  assign s1_adv   = !out_valid || out_ready;
  assign step     = s1_valid && s1_adv;
  assign in_ready = !s1_valid || s1_adv;

  via_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (s1_item),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.cmd     <= cmd_t'(cmd);
      s1_item.idx     <= bus_address[12:9];
      s1_item.wdata   <= write_data;
      s1_item.cycles  <= tick_cycles;
      s1_item.pa_pins <= port_a_pins;
      s1_item.pb_pins <= port_b_pins;
    end
    if (step) begin
      res <= core_res;
    end
  end

  assign read_data    = res.rdata;
  assign irq_line     = res.irq;
  assign port_a_drive = res.pa_drive;
  assign port_a_dir   = res.pa_dir;
  assign port_b_drive = res.pb_drive;
  assign port_b_dir   = res.pb_dir;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("in_ready low with empty input register");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_item))
    else $error("stalled item lost or changed");

  a_out_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared without an item");

  a_rdata_zero: assert property (@(posedge clk) disable iff (rst)
    step && s1_item.cmd != CMD_READ |=> read_data == '0)
    else $error("nonzero read byte for a non-read item");

endmodule

[dv/testbench.sv]
// Self-checking testbench for versatile_interface_adapter_unit: bus reads, writes
// and timer ticks against a cycle-free model of the register file, timers and IRQs.
// Depends on via_pkg (cmd_t, register indexes, flag positions, result_t).
module testbench;
  import via_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 550;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int CALM_TAIL    = 50;

  typedef struct packed {
    cmd_t        op;
    logic [12:0] addr;
    logic [7:0]  wbyte;
    logic [7:0]  cycles;
    logic [7:0]  pins_a;
    logic [7:0]  pins_b;
  } bus_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  read_data;
  logic        irq_line;
  logic [7:0]  port_a_drive;
  logic [7:0]  port_a_dir;
  logic [7:0]  port_b_drive;
  logic [7:0]  port_b_dir;
  bus_item_t   cur_item = '0;

  versatile_interface_adapter_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cur_item.op),
    .bus_address  (cur_item.addr),
    .write_data   (cur_item.wbyte),
    .tick_cycles  (cur_item.cycles),
    .port_a_pins  (cur_item.pins_a),
    .port_b_pins  (cur_item.pins_b),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .irq_line     (irq_line),
    .port_a_drive (port_a_drive),
    .port_a_dir   (port_a_dir),
    .port_b_drive (port_b_drive),
    .port_b_dir   (port_b_dir)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // adapter state as the model sees it
  logic [7:0]         pa_out = '0, pb_out = '0, pa_ddr = '0, pb_ddr = '0;
  logic [CNT_W-1:0]   t1_cnt = '0, t2_cnt = '0;
  logic [LATCH_W-1:0] t1_lat = '0, t2_lat = '0;
  logic [7:0]         sr_byte = '0, acr = '0, pcr = '0;
  logic [FLAG_W-1:0]  ifr = '0, ier = '0;

  bus_item_t pending_items[$];
  result_t   expected_results[$];
  int        accepted_total = 0;
  int        total_items = 0;
  int        checked_total = 0;
  int        error_count = 0;
  int        sender_gap = 0;
  int        receiver_gap = 0;
  int        cycle_count = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: result %0d: %s", $realtime, checked_total, msg);
    error_count++;
  endtask

  // falling from above zero to zero or below, signed
  function automatic bit timer_expired(logic [CNT_W-1:0] prior, logic [CNT_W-1:0] now);
    return $signed(prior) > 0 && $signed(now) <= 0;
  endfunction

  task automatic via_apply(input bus_item_t it, output result_t res);
    logic [3:0]       idx;
    logic [7:0]       rd;
    logic [7:0]       v;
    logic [CNT_W-1:0] prior;
    idx = it.addr[12:9];
    v   = it.wbyte;
    rd  = '0;
    case (it.op)
      CMD_READ: begin
        case (idx)
          REG_ORB:             rd = (pb_out & pb_ddr) | (it.pins_b & ~pb_ddr);
          REG_ORA, REG_ORA_NH: rd = (pa_out & pa_ddr) | (it.pins_a & ~pa_ddr);
          REG_DDRB:            rd = pb_ddr;
          REG_DDRA:            rd = pa_ddr;
          REG_T1CL: begin
            ifr[FLAG_T1] = 1'b0;
            rd = t1_cnt[7:0];
          end
          REG_T1CH:            rd = t1_cnt[15:8];
          REG_T1LL:            rd = t1_lat[7:0];
          REG_T1LH:            rd = t1_lat[15:8];
          REG_T2CL: begin
            ifr[FLAG_T2] = 1'b0;
            rd = t2_cnt[7:0];
          end
          REG_T2CH:            rd = t2_cnt[15:8];
          REG_SR:              rd = sr_byte;
          REG_ACR:             rd = acr;
          REG_PCR:             rd = pcr;
          REG_IFR:             rd = {|(ifr & ier), ifr};
          default:             rd = {1'b1, ier};
        endcase
      end
      CMD_WRITE: begin
        case (idx)
          REG_ORB:             pb_out = v;
          REG_ORA, REG_ORA_NH: pa_out = v;
          REG_DDRB:            pb_ddr = v;
          REG_DDRA:            pa_ddr = v;
          REG_T1CL, REG_T1LL:  t1_lat[7:0] = v;
          REG_T1CH: begin
            t1_lat[15:8] = v;
            t1_cnt = {16'b0, t1_lat};
            ifr[FLAG_T1] = 1'b0;
          end
          REG_T1LH:            t1_lat[15:8] = v;
          REG_T2CL:            t2_lat[7:0] = v;
          REG_T2CH: begin
            t2_cnt = {16'b0, v, t2_lat[7:0]};
            ifr[FLAG_T2] = 1'b0;
          end
          REG_SR:              sr_byte = v;
          REG_ACR:             acr = v;
          REG_PCR:             pcr = v;
          REG_IFR:             ifr = ifr & ~v[6:0];
          default: begin
            if (v[IER_SET]) ier = ier | v[6:0];
            else ier = ier & ~v[6:0];
          end
        endcase
      end
      CMD_TICK: begin
        prior  = t1_cnt;
        t1_cnt = prior - {24'b0, it.cycles};
        if (timer_expired(prior, t1_cnt)) begin
          ifr[FLAG_T1] = 1'b1;
          // free-run reloads once from the latch
          if (acr[ACR_T1_FREE]) t1_cnt = t1_cnt + {16'b0, t1_lat};
        end
        if (!acr[ACR_T2_HOLD]) begin
          prior  = t2_cnt;
          t2_cnt = prior - {24'b0, it.cycles};
          if (timer_expired(prior, t2_cnt)) ifr[FLAG_T2] = 1'b1;
        end
      end
      default: ;
    endcase
    res = {rd, |(ifr & ier), pa_out, pa_ddr, pb_out, pb_ddr};
  endtask

  task automatic queue_item(input cmd_t op, input logic [3:0] idx, input logic [7:0] wbyte,
                            input logic [7:0] cycles);
    bus_item_t it;
    it.op     = op;
    it.addr   = {idx, 9'($urandom)};
    it.wbyte  = wbyte;
    it.cycles = cycles;
    it.pins_a = 8'($urandom);
    it.pins_b = 8'($urandom);
    pending_items.push_back(it);
  endtask

  // mostly small high bytes so the timers actually run out within a few ticks
  function automatic logic [7:0] timer_high();
    return ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 1)) : 8'($urandom);
  endfunction

  function automatic bit in_tail();
    return pending_items.size() < CALM_TAIL;
  endfunction

  // driver: prediction happens at the edge an item is taken
  always @(posedge clk) begin : driver
    result_t want;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        via_apply(cur_item, want);
        expected_results.push_back(want);
        accepted_total++;
      end
      if (!in_valid || in_ready) begin
        if (sender_gap > 0) begin
          sender_gap--;
          in_valid <= 1'b0;
        end else if (!in_tail() && $urandom_range(0, 7) == 0) begin
          sender_gap = $urandom_range(0, 18);
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {read_data, irq_line, port_a_drive, port_a_dir, port_b_drive, port_b_dir};
        if (expected_results.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = expected_results.pop_front();
          if (got.rdata !== want.rdata)
            report_mismatch($sformatf("read_data %02h, want %02h", got.rdata, want.rdata));
          if (got.irq !== want.irq)
            report_mismatch($sformatf("irq_line %b, want %b", got.irq, want.irq));
          if (got.pa_drive !== want.pa_drive)
            report_mismatch($sformatf("port_a_drive %02h, want %02h",
                                      got.pa_drive, want.pa_drive));
          if (got.pa_dir !== want.pa_dir)
            report_mismatch($sformatf("port_a_dir %02h, want %02h", got.pa_dir, want.pa_dir));
          if (got.pb_drive !== want.pb_drive)
            report_mismatch($sformatf("port_b_drive %02h, want %02h",
                                      got.pb_drive, want.pb_drive));
          if (got.pb_dir !== want.pb_dir)
            report_mismatch($sformatf("port_b_dir %02h, want %02h", got.pb_dir, want.pb_dir));
        end
        checked_total++;
      end
      if (receiver_gap > 0) begin
        receiver_gap--;
        out_ready <= 1'b0;
      end else if (!in_tail() && $urandom_range(0, 11) == 0) begin
        receiver_gap = $urandom_range(0, 18);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int   r;
    int   stop_at;
    logic [3:0] idx;
    // directed: port mixing, timer expiry, free run, T2 hold, flag and enable handling
    queue_item(CMD_WRITE, REG_DDRB, 8'hF0, 8'h00);
    queue_item(CMD_WRITE, REG_ORB, 8'hFF, 8'hFF);
    queue_item(CMD_READ, REG_ORB, 8'h00, 8'h00);
    queue_item(CMD_WRITE, REG_ORA_NH, 8'h5A, 8'h00);
    queue_item(CMD_READ, REG_ORA, 8'hFF, 8'h00);
    queue_item(CMD_WRITE, REG_DDRA, 8'hFF, 8'h00);
    queue_item(CMD_READ, REG_ORA_NH, 8'h00, 8'h00);
    queue_item(CMD_WRITE, REG_IER, 8'hFF, 8'h00);
    queue_item(CMD_WRITE, REG_T1LL, 8'h03, 8'h00);
    queue_item(CMD_WRITE, REG_T1CH, 8'h00, 8'h00);
    queue_item(CMD_TICK, REG_ORB, 8'h00, 8'hFF);
    queue_item(CMD_READ, REG_IFR, 8'h00, 8'h00);
    queue_item(CMD_READ, REG_T1CL, 8'h00, 8'h00);
    queue_item(CMD_WRITE, REG_ACR, 8'h60, 8'h00);
    queue_item(CMD_WRITE, REG_T1CH, 8'h00, 8'h00);
    queue_item(CMD_WRITE, REG_T2CL, 8'h02, 8'h00);
    queue_item(CMD_WRITE, REG_T2CH, 8'h00, 8'h00);
    queue_item(CMD_TICK, REG_IER, 8'hFF, 8'h04);
    queue_item(CMD_TICK, REG_IER, 8'hFF, 8'h00);
    queue_item(CMD_READ, REG_T1LH, 8'h00, 8'h00);
    queue_item(CMD_WRITE, REG_IFR, 8'h7F, 8'h00);
    queue_item(CMD_WRITE, REG_IER, 8'h7F, 8'h00);
    queue_item(CMD_READ, REG_IER, 8'h00, 8'h00);
    queue_item(CMD_NONE, REG_SR, 8'hFF, 8'hFF);
    queue_item(CMD_READ, REG_T2CH, 8'h00, 8'h00);

    stop_at = pending_items.size() + RANDOM_ITEMS;
    while (pending_items.size() < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        // program a timer, let it run, then sometimes read back the low count of one timer
        if ($urandom_range(0, 1) == 0) begin
          queue_item(CMD_WRITE, REG_T1LL, 8'($urandom), 8'($urandom));
          queue_item(CMD_WRITE, REG_T1CH, timer_high(), 8'($urandom));
        end else begin
          queue_item(CMD_WRITE, REG_T2CL, 8'($urandom), 8'($urandom));
          queue_item(CMD_WRITE, REG_T2CH, timer_high(), 8'($urandom));
        end
        repeat ($urandom_range(1, 4)) queue_item(CMD_TICK, 4'($urandom), 8'($urandom),
                                                 8'($urandom));
        if ($urandom_range(0, 1) == 0)
          queue_item(CMD_READ, ($urandom_range(0, 1) == 0) ? REG_T1CL : REG_T2CL,
                     8'($urandom), 8'($urandom));
      end else if (r < 40) begin
        queue_item(CMD_TICK, 4'($urandom), 8'($urandom), 8'($urandom));
      end else if (r < 65) begin
        queue_item(CMD_READ, 4'($urandom), 8'($urandom), 8'($urandom));
      end else if (r < 95) begin
        idx = 4'($urandom);
        queue_item(CMD_WRITE, idx,
                   (idx == REG_T1CH || idx == REG_T1LH || idx == REG_T2CH) ?
                   timer_high() : 8'($urandom), 8'($urandom));
      end else begin
        queue_item(CMD_NONE, 4'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    total_items = pending_items.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (accepted_total < total_items || expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
